// ===== hdl/flsa_pkg.sv =====
// Package for the free list segment allocator: item types, codes and default sizes.
// Used by every module of the block; depends on nothing.
package flsa_pkg;

  localparam int unsigned HeapGranules = 4096;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned GranuleBytes = 16;

  localparam logic [1:0] ActAlloc = 2'd0;
  localparam logic [1:0] ActFree = 2'd1;
  localparam logic [1:0] ActInit = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic CfgSearchMode = 1'b0;
  localparam logic CfgHeapGranules = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] size_bytes;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_address;
    logic [15:0] granted_bytes;
  } rsp_t;

endpackage

// ===== hdl/free_list_segment_allocator.sv =====
// Free list segment allocator: address-ordered free segment table with first or best fit.
// An allocate or free scans the N table entries and may then shift the table; init only
// resets entry zero, the count and the heap size. One item at a time; the table memory
// port sets the rate. Asynchronous active-low reset sets the heap to one free segment at once;
// no clearing pass. Uses flsa_pkg and both memories.
module free_list_segment_allocator
  import flsa_pkg::*;
#(
  parameter int unsigned HEAP_GRANULES = HeapGranules,
  parameter int unsigned MAX_SEGMENTS = MaxSegments,
  parameter int unsigned GRANULE_BYTES = GranuleBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned SA = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned GW = $clog2(HEAP_GRANULES + 1) + 2;
  localparam int unsigned HA = $clog2(HEAP_GRANULES);
  localparam int unsigned GS = $clog2(GRANULE_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SCHK = 4'd2;
  localparam logic [3:0] S_PICK = 4'd3;
  localparam logic [3:0] S_PCHK = 4'd4;
  localparam logic [3:0] S_RMRD = 4'd5;
  localparam logic [3:0] S_RMWR = 4'd6;
  localparam logic [3:0] S_INRD = 4'd7;
  localparam logic [3:0] S_INWR = 4'd8;
  localparam logic [3:0] S_FBSZ = 4'd9;
  localparam logic [3:0] S_FDEC = 4'd10;
  localparam logic [3:0] S_FNXT = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state_q, state_d;
  logic mode_q;
  logic [12:0] heap_cfg_q;
  logic [GW-1:0] heap_now_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pick_q, pick_d;
  logic found_q, found_d;
  logic [GW-1:0] req_q, req_d;
  logic [GW-1:0] best_q, best_d;
  logic [GW-1:0] h_q, h_d;
  logic [GW-1:0] sz_q, sz_d;
  logic [GW-1:0] poff_q, poff_d, psz_q, psz_d;
  logic hasp_q, hasp_d;
  logic out_valid_q;
  rsp_t out_q, out_d, res_q;
  logic out_load;

  logic t_we;
  logic [SA-1:0] t_waddr, t_raddr;
  logic [GW-1:0] t_woff, t_wsize, t_roff, t_rsize;
  logic b_we;
  logic [HA-1:0] b_waddr, b_raddr;
  logic [GW-1:0] b_wdata, b_rdata;

  // Entry zero lives in registers so reset and init need no memory sweep.
  logic [GW-1:0] e0_off_q, e0_size_q, e0_off_d, e0_size_d;
  logic e0_we;
  logic rd_zero_q;
  logic [GW-1:0] r_off, r_size;
  logic [CW-1:0] raddr_full;

  flsa_seg_table #(.AW(SA), .DW(GW)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .woff_i(t_woff), .wsize_i(t_wsize),
    .raddr_i(t_raddr), .roff_o(t_roff), .rsize_o(t_rsize)
  );

  flsa_block_store #(.AW(HA), .DW(GW)) u_bstore (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  assign r_off = rd_zero_q ? e0_off_q : t_roff;
  assign r_size = rd_zero_q ? e0_size_q : t_rsize;
  assign t_raddr = raddr_full[SA-1:0];

  logic [GW-1:0] clamp_h;
  always_comb begin
    clamp_h = GW'(heap_cfg_q);
    if (heap_cfg_q < 13'd2) clamp_h = GW'(2);
    if (GW'(heap_cfg_q) > GW'(HEAP_GRANULES)) clamp_h = GW'(HEAP_GRANULES);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  logic [GW-1:0] g_addr;
  logic wr_at;
  logic [CW-1:0] wr_idx;
  logic [GW-1:0] wr_off, wr_size;

  assign g_addr = GW'(in_data_i.address >> GS);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    pick_d = pick_q;
    found_d = found_q;
    req_d = req_q;
    best_d = best_q;
    h_d = h_q;
    sz_d = sz_q;
    poff_d = poff_q;
    psz_d = psz_q;
    hasp_d = hasp_q;
    out_d = res_q;
    out_load = 1'b0;
    raddr_full = idx_q;
    wr_at = 1'b0;
    wr_idx = idx_q;
    wr_off = '0;
    wr_size = '0;
    b_we = 1'b0;
    b_waddr = h_q[HA-1:0];
    b_wdata = sz_q;
    b_raddr = h_q[HA-1:0];
    e0_off_d = e0_off_q;
    e0_size_d = e0_size_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          found_d = 1'b0;
          hasp_d = 1'b0;
          raddr_full = '0;
          req_d = GW'((17'(in_data_i.size_bytes) + 17'(GRANULE_BYTES - 1)) >> GS);
          h_d = g_addr - GW'(1);
          b_raddr = h_d[HA-1:0];
          case (in_data_i.action)
            ActAlloc: state_d = S_SCAN;
            ActFree: begin
              if (g_addr == '0 || h_d >= heap_now_q) begin
                out_d = '{status: StNoFit, block_address: '0, granted_bytes: '0};
                state_d = S_DONE;
              end else begin
                state_d = S_FBSZ;
              end
            end
            ActInit: begin
              count_d = CW'(1);
              e0_off_d = '0;
              e0_size_d = clamp_h - GW'(1);
              out_d = '{status: StOk, block_address: '0, granted_bytes: '0};
              state_d = S_DONE;
            end
            default: begin
              out_d = '{status: StOk, block_address: '0, granted_bytes: '0};
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // read of entry idx is in flight
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (idx_q >= count_q) begin
          if (!found_q) begin
            out_d = '{status: StNoFit, block_address: '0, granted_bytes: '0};
            state_d = S_DONE;
          end else begin
            idx_d = pick_q;
            raddr_full = pick_q;
            state_d = S_PICK;
          end
        end else if (r_size >= req_q && (!found_q || (mode_q && r_size < best_q))) begin
          found_d = 1'b1;
          pick_d = idx_q;
          best_d = r_size;
          if (!mode_q) begin
            idx_d = idx_q;
            raddr_full = idx_q;
            state_d = S_PICK;
          end else begin
            idx_d = idx_q + CW'(1);
            raddr_full = idx_d;
            state_d = S_SCAN;
          end
        end else begin
          idx_d = idx_q + CW'(1);
          raddr_full = idx_d;
          state_d = S_SCAN;
        end
      end
      S_PICK: begin
        state_d = S_PCHK;
      end
      S_PCHK: begin
        h_d = r_off;
        b_we = 1'b1;
        b_waddr = r_off[HA-1:0];
        out_d.status = StOk;
        out_d.block_address = 16'(r_off + GW'(1)) << GS;
        if (r_size - req_q >= GW'(2)) begin
          wr_at = 1'b1;
          wr_idx = idx_q;
          wr_off = r_off + GW'(1) + req_q;
          wr_size = r_size - req_q - GW'(1);
          b_wdata = req_q;
          out_d.granted_bytes = 16'(req_q) << GS;
          state_d = S_DONE;
        end else begin
          b_wdata = r_size;
          out_d.granted_bytes = 16'(r_size) << GS;
          idx_d = idx_q + CW'(1);
          raddr_full = idx_d;
          state_d = S_RMRD;
        end
      end
      S_RMRD: begin
        // shift entries down: entry idx-1 gets entry idx
        if (idx_q >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_RMWR;
        end
      end
      S_RMWR: begin
        wr_at = 1'b1;
        wr_idx = idx_q - CW'(1);
        wr_off = r_off;
        wr_size = r_size;
        idx_d = idx_q + CW'(1);
        raddr_full = idx_d;
        state_d = S_RMRD;
      end
      S_FBSZ: begin
        state_d = S_FDEC;
        sz_d = b_rdata;
      end
      S_FDEC: begin
        sz_d = b_rdata;
        if (h_q + GW'(1) + b_rdata > heap_now_q) begin
          out_d = '{status: StNoFit, block_address: '0, granted_bytes: '0};
          state_d = S_DONE;
        end else begin
          idx_d = '0;
          raddr_full = '0;
          state_d = S_FNXT;
        end
      end
      S_FNXT: begin
        // wait for the fetch of entry idx, then evaluate it in S_INRD as S_SCHK does
        state_d = S_INRD;
      end
      S_INRD: begin
        if (idx_q < count_q && r_off <= h_q) begin
          hasp_d = 1'b1;
          poff_d = r_off;
          psz_d = r_size;
          idx_d = idx_q + CW'(1);
          raddr_full = idx_d;
          state_d = S_FNXT;
        end else begin
          logic jn, jp;
          jn = (idx_q < count_q) && (h_q + GW'(1) + sz_q == r_off);
          jp = hasp_q && (poff_q + psz_q + GW'(1) == h_q);
          if ((idx_q < count_q && h_q + GW'(1) + sz_q > r_off) ||
              (hasp_q && poff_q + psz_q + GW'(1) > h_q)) begin
            out_d = '{status: StNoFit, block_address: '0, granted_bytes: '0};
            state_d = S_DONE;
          end else begin
            out_d = '{status: StOk, block_address: '0, granted_bytes: '0};
            if (jp && jn) begin
              wr_at = 1'b1;
              wr_idx = idx_q - CW'(1);
              wr_off = poff_q;
              wr_size = psz_q + GW'(2) + sz_q + r_size;
              idx_d = idx_q + CW'(1);
              raddr_full = idx_d;
              state_d = S_RMRD;
            end else if (jn) begin
              wr_at = 1'b1;
              wr_off = h_q;
              wr_size = sz_q + GW'(1) + r_size;
              state_d = S_DONE;
            end else if (jp) begin
              wr_at = 1'b1;
              wr_idx = idx_q - CW'(1);
              wr_off = poff_q;
              wr_size = psz_q + GW'(1) + sz_q;
              state_d = S_DONE;
            end else if (count_q >= CW'(MAX_SEGMENTS)) begin
              out_d.status = StFull;
              state_d = S_DONE;
            end else begin
              // insert at idx: shift up from the top
              pick_d = idx_q;
              idx_d = count_q;
              raddr_full = count_q - CW'(1);
              count_d = count_q + CW'(1);
              state_d = S_INWR;
              poff_d = h_q;
              psz_d = sz_q;
              hasp_d = 1'b0;
            end
          end
        end
      end
      S_INWR: begin
        // idx is destination; idx-1 read was issued in the previous cycle
        if (idx_q == pick_q) begin
          wr_at = 1'b1;
          wr_idx = pick_q;
          wr_off = poff_q;
          wr_size = psz_q;
          state_d = S_DONE;
        end else if (!hasp_q) begin
          hasp_d = 1'b1;
          raddr_full = idx_q - CW'(1);
        end else begin
          wr_at = 1'b1;
          wr_idx = idx_q;
          wr_off = r_off;
          wr_size = r_size;
          idx_d = idx_q - CW'(1);
          raddr_full = idx_d - CW'(1);
          hasp_d = 1'b0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    e0_we = wr_at && (wr_idx == '0);
    if (e0_we) begin
      e0_off_d = wr_off;
      e0_size_d = wr_size;
    end
  end

  assign t_we = wr_at && (wr_idx != '0);
  assign t_waddr = wr_idx[SA-1:0];
  assign t_woff = wr_off;
  assign t_wsize = wr_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= 1'b0;
      heap_cfg_q <= 13'd4096;
      heap_now_q <= GW'(HEAP_GRANULES);
      count_q <= CW'(1);
      e0_off_q <= '0;
      e0_size_q <= GW'(HEAP_GRANULES - 1);
      out_valid_q <= 1'b0;
      rd_zero_q <= 1'b0;
      found_q <= 1'b0;
      hasp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
      hasp_q <= hasp_d;
      e0_off_q <= e0_off_d;
      e0_size_q <= e0_size_d;
      rd_zero_q <= (raddr_full == '0);
      if (state_q == S_IDLE && in_valid_i && in_data_i.action == ActInit) begin
        heap_now_q <= clamp_h;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgSearchMode) mode_q <= cfg_data_i[0];
        else heap_cfg_q <= cfg_data_i;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pick_q <= pick_d;
    req_q <= req_d;
    best_q <= best_d;
    h_q <= h_d;
    sz_q <= sz_d;
    poff_q <= poff_d;
    psz_q <= psz_d;
    res_q <= out_d;
    if (out_load) out_q <= out_d;
  end

endmodule

// ===== hdl/flsa_seg_table.sv =====
// Segment table memory of the free list segment allocator: offset and size per entry.
// One write port and one registered read port. Depends on flsa_pkg only.
module flsa_seg_table
  import flsa_pkg::*;
#(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] woff_i,
  input  logic [DW-1:0] wsize_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] roff_o,
  output logic [DW-1:0] rsize_o
);

  logic [DW-1:0] off_mem [2**AW];
  logic [DW-1:0] size_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      off_mem[waddr_i] <= woff_i;
      size_mem[waddr_i] <= wsize_i;
    end
    roff_o <= off_mem[raddr_i];
    rsize_o <= size_mem[raddr_i];
  end

endmodule

// ===== hdl/flsa_block_store.sv =====
// Per-block granted size memory of the free list segment allocator.
// One write port and one registered read port. Depends on flsa_pkg only.
module flsa_block_store
  import flsa_pkg::*;
#(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
